[src/spst_pkg.sv]
// ----------------------------------------------------------------------------
// spst_pkg: shared definitions for the sorted pair table
// Table size, derived widths and the command codes that the core decodes.
// ----------------------------------------------------------------------------
package spst_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int HALF_W      = 32;
    localparam int ENTRY_W     = 2 * HALF_W;
    localparam int POS_W       = 8;
    localparam int CMD_W       = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_LOWER  = 3'd2,
        CMD_UPPER  = 3'd3,
        CMD_FIND   = 3'd4
    } cmd_t;

endpackage

[src/spst_ram.sv]
// ----------------------------------------------------------------------------
// spst_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module spst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/sorted_pair_table_bound_search_core.sv]
// ----------------------------------------------------------------------------
// sorted_pair_table_bound_search_core: sorted pair table with bound search
// Keeps signed (first, second) pairs in lexicographic order in a RAM and
// answers strict lower, strict upper and exact-find queries.
// ----------------------------------------------------------------------------
// Usage: a command word (command, key_first, key_second) is taken at a rising
// edge where start is high and busy is low. Clear and unused codes return no
// word and leave the core idle. Every other command returns one result word
// (hit, position, table_full) marked by done for exactly one cycle; the
// receiver cannot hold it off.
// Search: a query runs a binary search with one shared 64-bit comparator.
// Each probe is a RAM read in S_PROBE, then a compare in S_CHECK.
// An insert runs the upper-bound search, then moves every entry at or above
// the insertion point up by one through the single RAM port pair, reading in
// S_SHIFT_RD and writing in S_SHIFT_WR, then writes the new pair in S_PLACE.
// An insert into a full table returns table_full in the next cycle.
// Reset clears the entry count and the sequencer; RAM contents need no reset
// since only entries below the count are read.
// ----------------------------------------------------------------------------
module sorted_pair_table_bound_search_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [spst_pkg::CMD_W-1:0]              command,
    input  logic signed [spst_pkg::HALF_W-1:0]      key_first,
    input  logic signed [spst_pkg::HALF_W-1:0]      key_second,
    output logic                                    done,
    output logic                                    hit,
    output logic [spst_pkg::POS_W-1:0]              position,
    output logic                                    table_full
);

    localparam int IDX_W = spst_pkg::IDX_W;
    localparam int CNT_W = spst_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE
    } state_t;

    state_t                           state_reg, state_next;
    spst_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [spst_pkg::ENTRY_W-1:0]     key_reg, key_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [CNT_W-1:0]                 lo_reg, lo_next;
    logic [CNT_W-1:0]                 hi_reg, hi_next;
    logic [IDX_W-1:0]                 mid_reg, mid_next;
    logic                             found_vld_reg, found_vld_next;
    logic [IDX_W-1:0]                 found_reg, found_next;
    logic [IDX_W-1:0]                 ptr_reg, ptr_next;
    logic                             done_reg, done_next;
    logic                             hit_reg, hit_next;
    logic [spst_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                             full_reg, full_next;

    logic [CNT_W-1:0]                 mid_calc;
    logic [spst_pkg::ENTRY_W-1:0]     rd_data;
    logic [spst_pkg::ENTRY_W-1:0]     wr_data;
    logic [IDX_W-1:0]                 rd_addr;
    logic [IDX_W-1:0]                 wr_addr;
    logic                             wr_en;
    logic                             entry_lt;
    logic                             entry_eq;
    logic                             entry_gt;
    logic                             table_is_full;

    // Flipping the sign bits turns the signed lexicographic order into a
    // plain unsigned compare of the concatenated pair.
    assign key_next = (state_reg == S_IDLE)
                    ? {~key_first[spst_pkg::HALF_W-1], key_first[spst_pkg::HALF_W-2:0],
                       ~key_second[spst_pkg::HALF_W-1], key_second[spst_pkg::HALF_W-2:0]}
                    : key_reg;

    assign mid_calc = lo_reg + ((hi_reg - lo_reg - CNT_W'(1)) >> 1);

    // The shared comparator: every probe goes through this one unit.
    assign entry_lt = (rd_data < key_reg);
    assign entry_eq = (rd_data == key_reg);
    assign entry_gt = !entry_lt && !entry_eq;

    assign table_is_full = (count_reg >= CNT_W'(spst_pkg::TABLE_DEPTH));

    spst_ram #(
        .WIDTH (spst_pkg::ENTRY_W),
        .DEPTH (spst_pkg::TABLE_DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        rd_addr = (state_reg == S_SHIFT_RD) ? (ptr_reg - IDX_W'(1)) : mid_calc[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = rd_data;
        if (state_reg == S_SHIFT_WR)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == S_PLACE)
        begin
            wr_en   = 1'b1;
            wr_addr = found_reg;
            wr_data = key_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        found_vld_next = found_vld_reg;
        found_next     = found_reg;
        ptr_next       = ptr_reg;
        done_next      = 1'b0;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        full_next      = full_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next       = spst_pkg::cmd_t'(command);
                    lo_next        = '0;
                    hi_next        = count_reg;
                    found_vld_next = 1'b0;
                    found_next     = '0;
                    case (spst_pkg::cmd_t'(command)) inside
                        spst_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        spst_pkg::CMD_INSERT:
                        begin
                            if (table_is_full)
                            begin
                                done_next = 1'b1;
                                hit_next  = 1'b0;
                                pos_next  = '0;
                                full_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_PROBE;
                            end
                        end
                        spst_pkg::CMD_LOWER, spst_pkg::CMD_UPPER, spst_pkg::CMD_FIND:
                        begin
                            state_next = S_PROBE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc[IDX_W-1:0];
                    state_next = S_CHECK;
                end
                else if (cmd_reg == spst_pkg::CMD_INSERT)
                begin
                    // No greater entry means the new pair goes at the end.
                    if (!found_vld_reg)
                    begin
                        found_next = count_reg[IDX_W-1:0];
                    end
                    ptr_next   = count_reg[IDX_W-1:0];
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    hit_next   = found_vld_reg;
                    pos_next   = found_vld_reg ? spst_pkg::POS_W'(found_reg) : '0;
                    full_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end

            S_CHECK:
            begin
                state_next = S_PROBE;
                case (cmd_reg)
                    spst_pkg::CMD_LOWER:
                    begin
                        if (entry_lt)
                        begin
                            found_vld_next = 1'b1;
                            found_next     = mid_reg;
                            lo_next        = CNT_W'(mid_reg) + CNT_W'(1);
                        end
                        else
                        begin
                            hi_next = CNT_W'(mid_reg);
                        end
                    end
                    spst_pkg::CMD_FIND:
                    begin
                        if (entry_eq)
                        begin
                            done_next  = 1'b1;
                            hit_next   = 1'b1;
                            pos_next   = spst_pkg::POS_W'(mid_reg);
                            full_next  = 1'b0;
                            state_next = S_IDLE;
                        end
                        else if (entry_gt)
                        begin
                            hi_next = CNT_W'(mid_reg);
                        end
                        else
                        begin
                            lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        // Strict upper bound, also used to place an insert.
                        if (entry_gt)
                        begin
                            found_vld_next = 1'b1;
                            found_next     = mid_reg;
                            hi_next        = CNT_W'(mid_reg);
                        end
                        else
                        begin
                            lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                        end
                    end
                endcase
            end

            S_SHIFT_RD:
            begin
                if (ptr_reg == found_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                ptr_next   = ptr_reg - IDX_W'(1);
                state_next = S_SHIFT_RD;
            end

            S_PLACE:
            begin
                count_next = count_reg + CNT_W'(1);
                done_next  = 1'b1;
                hit_next   = 1'b1;
                pos_next   = spst_pkg::POS_W'(found_reg);
                full_next  = 1'b0;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            found_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            found_vld_reg <= found_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        found_reg <= found_next;
        ptr_reg   <= ptr_next;
        hit_reg   <= hit_next;
        pos_reg   <= pos_next;
        full_reg  <= full_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign hit        = hit_reg;
    assign position   = pos_reg;
    assign table_full = full_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(spst_pkg::TABLE_DEPTH))
        else $error("entry count exceeds the table depth");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (lo_reg <= hi_reg) && (hi_reg <= count_reg))
        else $error("search window left the valid range");

    a_count_grows_on_place: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_PLACE)
            || (count_reg == '0))
        else $error("entry count changed outside an insert or clear");

    a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (full_reg || !hit_reg)) |-> (!hit_reg && pos_reg == '0))
        else $error("miss or dropped insert reported with a position");

    a_shift_stays_above: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_WR) |-> (ptr_reg > found_reg))
        else $error("entry move went below the insertion point");

endmodule
